@@ rtl/core/egee_pkg.sv @@
// Shared types, codes and constants of the exp-Gauss-exp shape evaluator.
`timescale 1ns / 1ps

package egee_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CENTER     = 3'd0;
  localparam logic [2:0] CFG_INV_LEFT   = 3'd1;
  localparam logic [2:0] CFG_INV_RIGHT  = 3'd2;
  localparam logic [2:0] CFG_TAIL_LEFT  = 3'd3;
  localparam logic [2:0] CFG_TAIL_RIGHT = 3'd4;

  // Region codes.
  localparam logic [1:0] REGION_LEFT  = 2'd0;
  localparam logic [1:0] REGION_CORE  = 2'd1;
  localparam logic [1:0] REGION_RIGHT = 2'd2;

  // Saturation level of |t|, 64.0 in Q.12.
  localparam logic [18:0] T_SAT = 19'd262144;

  // log2(e) in Q.30 and ln(2) in Q.32.
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [63:0] LN2_Q32   = 64'd2977044472;

  typedef struct packed {
    logic signed [15:0] center;
    logic [15:0]        inv_width_left;
    logic [15:0]        inv_width_right;
    logic [14:0]        tail_start_left;
    logic [14:0]        tail_start_right;
  } cfg_t;

  // Negated exponent in Q.25 with the tags that travel alongside it.
  typedef struct packed {
    logic        valid;
    logic [1:0]  region;
    logic        clamped;
    logic [34:0] g;
  } arg_t;

  // 2^(-x/ln2) = exp(-x) in Q.32 by a Taylor series through the x^20 term, each term truncated.
  function automatic logic [32:0] pow2_entry(input logic [63:0] x);
    logic [63:0] term;
    logic [63:0] sum;
    term = 64'd1 << 32;
    sum  = 64'd1 << 32;
    term = ((term * x) >> 32) / 64'd1;  sum = sum - term;
    term = ((term * x) >> 32) / 64'd2;  sum = sum + term;
    term = ((term * x) >> 32) / 64'd3;  sum = sum - term;
    term = ((term * x) >> 32) / 64'd4;  sum = sum + term;
    term = ((term * x) >> 32) / 64'd5;  sum = sum - term;
    term = ((term * x) >> 32) / 64'd6;  sum = sum + term;
    term = ((term * x) >> 32) / 64'd7;  sum = sum - term;
    term = ((term * x) >> 32) / 64'd8;  sum = sum + term;
    term = ((term * x) >> 32) / 64'd9;  sum = sum - term;
    term = ((term * x) >> 32) / 64'd10; sum = sum + term;
    term = ((term * x) >> 32) / 64'd11; sum = sum - term;
    term = ((term * x) >> 32) / 64'd12; sum = sum + term;
    term = ((term * x) >> 32) / 64'd13; sum = sum - term;
    term = ((term * x) >> 32) / 64'd14; sum = sum + term;
    term = ((term * x) >> 32) / 64'd15; sum = sum - term;
    term = ((term * x) >> 32) / 64'd16; sum = sum + term;
    term = ((term * x) >> 32) / 64'd17; sum = sum - term;
    term = ((term * x) >> 32) / 64'd18; sum = sum + term;
    term = ((term * x) >> 32) / 64'd19; sum = sum - term;
    term = ((term * x) >> 32) / 64'd20; sum = sum + term;
    return sum[32:0];
  endfunction

endpackage

@@ rtl/core/egee_cfg_regs.sv @@
// Configuration register file of the exp-Gauss-exp shape evaluator.
`timescale 1ns / 1ps

module egee_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [2:0]      wr_index,
  input  logic [15:0]     wr_data,
  output egee_pkg::cfg_t  cfg
);

  egee_pkg::cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.center           <= 16'sd0;
      regs.inv_width_left   <= 16'd256;
      regs.inv_width_right  <= 16'd256;
      regs.tail_start_left  <= 15'd4096;
      regs.tail_start_right <= 15'd4096;
    end else if (wr_en) begin
      unique case (wr_index)
        egee_pkg::CFG_CENTER:     regs.center           <= $signed(wr_data);
        egee_pkg::CFG_INV_LEFT:   regs.inv_width_left   <= wr_data;
        egee_pkg::CFG_INV_RIGHT:  regs.inv_width_right  <= wr_data;
        egee_pkg::CFG_TAIL_LEFT:  regs.tail_start_left  <= wr_data[14:0];
        egee_pkg::CFG_TAIL_RIGHT: regs.tail_start_right <= wr_data[14:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

@@ rtl/core/egee_arg.sv @@
// Argument stages: scaled distance, region choice and the negated exponent.
`timescale 1ns / 1ps

module egee_arg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [15:0] sample,
  input  egee_pkg::cfg_t     cfg,
  output egee_pkg::arg_t     arg
);

  // Stage A: |sample - center| times the reciprocal width of that side.
  logic signed [16:0] diff;
  logic               left_a;
  logic [15:0]        dmag;
  logic [15:0]        inv_sel;

  logic               a_valid;
  logic               a_left;
  logic [31:0]        a_prod;

  assign diff    = 17'(sample) - 17'(cfg.center);
  assign left_a  = diff[16];
  assign dmag    = left_a ? 16'(-diff) : diff[15:0];
  assign inv_sel = left_a ? cfg.inv_width_left : cfg.inv_width_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_left <= left_a;
    a_prod <= dmag * inv_sel;
  end

  // Stage B: saturate |t|, pick the region and the two multiplier operands.
  logic [23:0] m_raw;
  logic        sat;
  logic [18:0] m_sat;
  logic [14:0] tail_sel;
  logic        in_tail;
  logic [19:0] two_m_minus_a;

  logic        b_valid;
  logic [1:0]  b_region;
  logic        b_clamped;
  logic [14:0] b_op1;
  logic [19:0] b_op2;

  assign m_raw         = a_prod[31:8];
  assign sat           = m_raw > 24'(egee_pkg::T_SAT);
  assign m_sat         = sat ? egee_pkg::T_SAT : m_raw[18:0];
  assign tail_sel      = a_left ? cfg.tail_start_left : cfg.tail_start_right;
  assign in_tail       = m_sat > 19'(tail_sel);
  assign two_m_minus_a = {m_sat, 1'b0} - 20'(tail_sel);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
  end

  // In the core m never exceeds the tail start, so it fits in 15 bits.
  always_ff @(posedge clk) begin
    b_clamped <= sat;
    if (in_tail) begin
      b_region <= a_left ? egee_pkg::REGION_LEFT : egee_pkg::REGION_RIGHT;
      b_op1    <= tail_sel;
      b_op2    <= two_m_minus_a;
    end else begin
      b_region <= egee_pkg::REGION_CORE;
      b_op1    <= m_sat[14:0];
      b_op2    <= 20'(m_sat);
    end
  end

  // Stage C: g = a * (2m - a) in a tail, m * m in the core.
  egee_pkg::arg_t c_arg;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_arg.valid <= 1'b0;
    end else begin
      c_arg.valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    c_arg.region  <= b_region;
    c_arg.clamped <= b_clamped;
    c_arg.g       <= b_op1 * b_op2;
  end

  assign arg = c_arg;

endmodule

@@ rtl/core/egee_exp.sv @@
// Exponential stages: exp(-g) as a table entry of 2^-frac and a right shift.
`timescale 1ns / 1ps

module egee_exp #(
  parameter int EXP_TABLE_DEPTH = 256,
  parameter int EXP_MIN_ARG     = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  egee_pkg::arg_t arg,
  output logic           out_valid,
  output logic [15:0]    out_value,
  output logic [1:0]     out_region,
  output logic           out_clamped
);

  localparam logic [34:0] LIMIT = 35'(EXP_MIN_ARG) << 25;
  localparam int GW = $clog2((EXP_MIN_ARG << 25) + 1);
  localparam int PW = GW - 24;
  localparam int KW = $clog2(EXP_TABLE_DEPTH);
  localparam logic [KW:0] DEPTH_V = (KW + 1)'(EXP_TABLE_DEPTH);

  // Table of 2^(-k/EXP_TABLE_DEPTH) in Q.32.
  logic [32:0] pow2_rom [EXP_TABLE_DEPTH];

  for (genvar kk = 0; kk < EXP_TABLE_DEPTH; kk++) begin : g_rom
    localparam logic [63:0] X = (64'(kk) * egee_pkg::LN2_Q32) / EXP_TABLE_DEPTH;
    assign pow2_rom[kk] = egee_pkg::pow2_entry(X);
  end

  // Stage D: underflow test and the two partial products of g * log2(e).
  logic          d_valid;
  logic          d_zero;
  logic          d_clamped;
  logic [1:0]    d_region;
  logic [46:0]   d_pl;
  logic [GW+14:0] d_ph;
  logic          under;

  assign under = arg.g > LIMIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= arg.valid;
    end
  end

  always_ff @(posedge clk) begin
    d_zero    <= under;
    d_clamped <= arg.clamped | under;
    d_region  <= arg.region;
    d_pl      <= arg.g[15:0] * egee_pkg::LOG2E_Q30;
    d_ph      <= arg.g[GW-1:16] * egee_pkg::LOG2E_Q30;
  end

  // Stage E: join the partial products; z = product >> 23 splits into p and f.
  logic [GW+30:0] prod;
  logic           e_valid;
  logic           e_zero;
  logic           e_clamped;
  logic [1:0]     e_region;
  logic [31:0]    e_f;
  logic [PW-1:0]  e_p;

  assign prod = {d_ph, 16'd0} + (GW + 31)'(d_pl);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    e_zero    <= d_zero;
    e_clamped <= d_clamped;
    e_region  <= d_region;
    e_f       <= prod[54:23];
    e_p       <= prod[GW+30:55];
  end

  // Stage F: table index k = (f * depth) >> 32.
  logic [KW+32:0] kprod;
  logic           f_valid;
  logic           f_zero;
  logic           f_clamped;
  logic [1:0]     f_region;
  logic [KW-1:0]  f_k;
  logic [PW-1:0]  f_p;

  assign kprod = e_f * DEPTH_V;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    f_zero    <= e_zero;
    f_clamped <= e_clamped;
    f_region  <= e_region;
    f_k       <= kprod[32 +: KW];
    f_p       <= e_p;
  end

  // Stage G: table read.
  logic          g_valid;
  logic          g_zero;
  logic          g_clamped;
  logic [1:0]    g_region;
  logic [32:0]   g_t;
  logic [PW-1:0] g_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else begin
      g_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    g_zero    <= f_zero;
    g_clamped <= f_clamped;
    g_region  <= f_region;
    g_t       <= pow2_rom[f_k];
    g_p       <= f_p;
  end

  // Stage H: round half up and shift right by 17 + p. Once p exceeds 16 the
  // table entry plus the rounding bit is below the shift, so the result is 0.
  logic        p_big;
  logic [4:0]  p_small;
  logic [33:0] rounded;
  logic [33:0] shifted;
  logic [15:0] value;

  assign p_big   = g_p > PW'(16);
  assign p_small = g_p[4:0];
  assign rounded = 34'(g_t) + (34'd1 << (6'd16 + 6'(p_small)));
  assign shifted = rounded >> (6'd17 + 6'(p_small));
  assign value   = (g_zero || p_big) ? 16'd0 : shifted[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_value   <= value;
    out_region  <= g_region;
    out_clamped <= g_clamped;
  end

endmodule

@@ rtl/core/exp_gauss_exp_shape_eval.sv @@
// Top level of the exp-Gauss-exp shape evaluator.
`timescale 1ns / 1ps

// The block evaluates an asymmetric Gaussian core with exponential tails for one
// signed Q4.12 sample per clock cycle. A request is taken at every rising edge at
// which start is high; busy is always low, so start may be held high to stream
// samples back to back. Each result appears on shape_value, region and clamped for
// exactly one cycle with done high, and results leave in request order. The
// receiver cannot stall the block, so it must capture each result in the cycle in
// which done is high. In the pipeline, three stages form the scaled distance t,
// pick the region and multiply out the negated exponent; five stages test for
// underflow, multiply by log2(e) in two partial products, form the table index,
// read the 2^-frac table and round and shift the result. Configuration registers
// are written through the cfg_valid / cfg_ready channel, which is always ready;
// they should only be changed while no request is still in the pipeline.
module exp_gauss_exp_shape_eval #(
  parameter int EXP_TABLE_DEPTH = 256,
  parameter int EXP_MIN_ARG     = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] sample,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output logic [15:0]        shape_value,
  output logic [1:0]         region,
  output logic               clamped
);

  egee_pkg::cfg_t cfg;
  egee_pkg::arg_t arg;
  logic           accept;

  // The pipeline never holds back, so a request is taken whenever start is high.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  egee_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Distance, region and exponent argument.
  egee_arg u_arg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .sample   (sample),
    .cfg      (cfg),
    .arg      (arg)
  );

  // Exponential and output register.
  egee_exp #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
    .EXP_MIN_ARG     (EXP_MIN_ARG)
  ) u_exp (
    .clk         (clk),
    .rst         (rst),
    .arg         (arg),
    .out_valid   (done),
    .out_value   (shape_value),
    .out_region  (region),
    .out_clamped (clamped)
  );

endmodule
